/* src/vcs_pkg.sv */
// Shared types, widths and codes for the velocity command smoother.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package vcs_pkg;

	localparam int VEL_WIDTH = 24;
	localparam int AGE_WIDTH = 16;

	localparam int ALPHA_W = 17;
	localparam int SCALE_W = 16;
	localparam int TMO_W   = 16;
	localparam int DB_W    = 16;

	localparam int ALPHA_FRAC = 16;
	localparam int SCALE_FRAC = 12;

	// compare widths wide enough for both sides
	localparam int MAG_W = (VEL_WIDTH > DB_W) ? VEL_WIDTH : DB_W;
	localparam int AGEC_W = (AGE_WIDTH > TMO_W) ? AGE_WIDTH : TMO_W;

	// shared multiplier: (VEL_WIDTH+1) x (ALPHA_W+1), both signed
	localparam int MUL_A_W = VEL_WIDTH + 1;
	localparam int MUL_B_W = ALPHA_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = ALPHA_W;

	localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_LIN = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_ANG = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ANG_SCALE = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND  = 3'd4;

	localparam logic [ALPHA_W-1:0] ALPHA_LIN_RST = 17'd19661;
	localparam logic [ALPHA_W-1:0] ALPHA_ANG_RST = 17'd45875;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'd65536;
	localparam logic [SCALE_W-1:0] ANG_SCALE_RST = 16'd4096;
	localparam logic [TMO_W-1:0]   TIMEOUT_RST   = 16'd5;
	localparam logic [DB_W-1:0]    DEADBAND_RST  = 16'd7;

	localparam logic [1:0] CMD_VEL  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;

	localparam logic [1:0] KIND_MOVE     = 2'd0;
	localparam logic [1:0] KIND_DEADBAND = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
	localparam logic [1:0] KIND_STOP_ACK = 2'd3;

	localparam logic [1:0] MUL_X     = 2'd0;
	localparam logic [1:0] MUL_Y     = 2'd1;
	localparam logic [1:0] MUL_YAW   = 2'd2;
	localparam logic [1:0] MUL_SCALE = 2'd3;

	typedef struct packed {
		logic [ALPHA_W-1:0] lin_weight;
		logic [ALPHA_W-1:0] yaw_weight;
		logic [SCALE_W-1:0] yaw_gain;
		logic [TMO_W-1:0]   timeout;
		logic [DB_W-1:0]    deadband;
	} vcs_cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       clear;
		logic       prime;
		logic       start_motion;
		logic       age_step;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       wb_en;
		logic [1:0] wb_sel;
		logic       load_out;
		logic [1:0] out_kind;
	} vcs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] command;
		logic       stop_zone;
		logic       primed;
		logic       active;
		logic       timeout_hit;
		logic       out_busy;
	} vcs_stat_t;

endpackage

`default_nettype wire

/* src/vcs_cmd_if.sv */
// Input channel: command code and raw velocity triple.
// Depends on vcs_pkg.
`default_nettype none

interface vcs_cmd_if import vcs_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [1:0]           command;
	logic [VEL_WIDTH-1:0] vx_in;
	logic [VEL_WIDTH-1:0] vy_in;
	logic [VEL_WIDTH-1:0] yaw_in;

	modport source (output valid, command, vx_in, vy_in, yaw_in, input ready);
	modport sink (input valid, command, vx_in, vy_in, yaw_in, output ready);
endinterface

`default_nettype wire

/* src/vcs_move_if.sv */
// Output channel: move command kind and velocity triple.
// Depends on vcs_pkg.
`default_nettype none

interface vcs_move_if import vcs_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [1:0]           kind;
	logic [VEL_WIDTH-1:0] vx_out;
	logic [VEL_WIDTH-1:0] vy_out;
	logic [VEL_WIDTH-1:0] yaw_out;

	modport source (output valid, kind, vx_out, vy_out, yaw_out, input ready);
	modport sink (input valid, kind, vx_out, vy_out, yaw_out, output ready);
endinterface

`default_nettype wire

/* src/vcs_cfg_if.sv */
// Configuration write channel: register address and write data.
// Depends on vcs_pkg.
`default_nettype none

interface vcs_cfg_if import vcs_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* src/velocity_command_smoother_top.sv */
// Velocity command smoother: EMA filter on vx, vy, yaw with an idle watchdog.
// Per item, after decode: a filtered command runs three EMA products, then the yaw gain, on the
// single shared multiplier; a first sample primes the filters and runs only the yaw gain; stop,
// deadband and timeout go straight to the output load; a tick or unused code yields no result.
// A pending result waits in the output register while the next item is being worked on.
// arst_n clears filters, watchdog age, control state and loads register defaults.
`default_nettype none

module velocity_command_smoother_top import vcs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	vcs_cfg_if.sink   cfg,
	vcs_cmd_if.sink   in_ch,
	vcs_move_if.source out_ch
);

	vcs_cfg_t  regs;
	vcs_cmd_t  cmd;
	vcs_stat_t stat;

	vcs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	vcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.cmd       (cmd),
		.stat      (stat),
		.command   (in_ch.command),
		.vx_in     (in_ch.vx_in),
		.vy_in     (in_ch.vy_in),
		.yaw_in    (in_ch.yaw_in),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.kind      (out_ch.kind),
		.vx_out    (out_ch.vx_out),
		.vy_out    (out_ch.vy_out),
		.yaw_out   (out_ch.yaw_out)
	);

`ifndef NO_ASSERTIONS
	// one item at a time: a transfer drops ready for at least the decode cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input taken while previous item still in work");

	// zero moves carry zero velocities
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.kind != KIND_MOVE) |->
			(out_ch.vx_out == '0) && (out_ch.vy_out == '0) && (out_ch.yaw_out == '0))
		else $error("zero move with nonzero payload");

	// every filter write-back follows a matching multiplier issue in the previous cycle
	a_wb_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb_en |-> $past(cmd.mul_en) && ($past(cmd.mul_sel) == cmd.wb_sel))
		else $error("write-back without matching product");

	// a new result is never loaded over one that is still unclaimed
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !stat.out_busy)
		else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

/* src/vcs_cfg_regs.sv */
// Configuration register bank, written through the cfg channel.
// Depends on vcs_pkg and vcs_cfg_if.
`default_nettype none

module vcs_cfg_regs import vcs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vcs_cfg_if.sink    cfg,
	output vcs_cfg_t   regs
);

	vcs_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.lin_weight <= ALPHA_LIN_RST;
			regs_q.yaw_weight <= ALPHA_ANG_RST;
			regs_q.yaw_gain   <= ANG_SCALE_RST;
			regs_q.timeout    <= TIMEOUT_RST;
			regs_q.deadband   <= DEADBAND_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.addr)
				REG_ALPHA_LIN: regs_q.lin_weight <= cfg.data;
				REG_ALPHA_ANG: regs_q.yaw_weight <= cfg.data;
				REG_ANG_SCALE: regs_q.yaw_gain   <= cfg.data[SCALE_W-1:0];
				REG_TIMEOUT:   regs_q.timeout    <= cfg.data[TMO_W-1:0];
				REG_DEADBAND:  regs_q.deadband   <= cfg.data[DB_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/vcs_datapath.sv */
// Datapath: input latch, filter state, watchdog age, shared multiplier
// and output register. Driven by vcs_ctrl commands; depends on vcs_pkg.
`default_nettype none

module vcs_datapath import vcs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire vcs_cfg_t             regs,
	input  wire vcs_cmd_t             cmd,
	output vcs_stat_t                 stat,
	input  wire logic [1:0]           command,
	input  wire logic [VEL_WIDTH-1:0] vx_in,
	input  wire logic [VEL_WIDTH-1:0] vy_in,
	input  wire logic [VEL_WIDTH-1:0] yaw_in,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [1:0]                kind,
	output logic [VEL_WIDTH-1:0]      vx_out,
	output logic [VEL_WIDTH-1:0]      vy_out,
	output logic [VEL_WIDTH-1:0]      yaw_out
);

	localparam int VW = VEL_WIDTH;
	localparam int SAT_W = PROD_W - VW + 1;

	logic [1:0]           command_s1;
	logic signed [VW-1:0] vx_s1, vy_s1, yaw_s1;
	logic signed [VW-1:0] fvx_q, fvy_q, fyaw_q;
	logic                 primed_q, active_q;
	logic [AGE_WIDTH-1:0] age_q, age_next;
	logic signed [PROD_W-1:0] prod_q;

	logic                 out_valid_q;
	logic [1:0]           kind_q;
	logic [VW-1:0]        vx_out_q, vy_out_q, yaw_out_q;

	logic [ALPHA_W-1:0]   lin_weight_eff, yaw_weight_eff;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [VW-1:0] wb_old;
	logic signed [PROD_W-1:0] ema_sum, scl;
	logic [SAT_W-1:0]     scl_top;
	logic [VW-1:0]        yaw_sat;
	logic [VW-1:0]        mag_x, mag_y, mag_yaw;

	// weights above one act as exactly one
	assign lin_weight_eff = regs.lin_weight[ALPHA_W-1] ? ALPHA_ONE : regs.lin_weight;
	assign yaw_weight_eff = regs.yaw_weight[ALPHA_W-1] ? ALPHA_ONE : regs.yaw_weight;

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_s1 <= command;
			vx_s1      <= vx_in;
			vy_s1      <= vy_in;
			yaw_s1     <= yaw_in;
		end
	end

	// magnitudes; the most negative value wraps to 2^(VW-1), still exact unsigned
	assign mag_x   = vx_s1[VW-1]  ? VW'(-vx_s1)  : vx_s1;
	assign mag_y   = vy_s1[VW-1]  ? VW'(-vy_s1)  : vy_s1;
	assign mag_yaw = yaw_s1[VW-1] ? VW'(-yaw_s1) : yaw_s1;

	assign age_next = (&age_q) ? age_q : age_q + AGE_WIDTH'(1);

	assign stat.command     = command_s1;
	assign stat.stop_zone   = (MAG_W'(mag_x) < MAG_W'(regs.deadband))
		&& (MAG_W'(mag_y) < MAG_W'(regs.deadband))
		&& (MAG_W'(mag_yaw) < MAG_W'(regs.deadband));
	assign stat.primed      = primed_q;
	assign stat.active      = active_q;
	assign stat.timeout_hit = AGEC_W'(age_next) > AGEC_W'(regs.timeout);
	assign stat.out_busy    = out_valid_q && !out_ready;

	// shared multiplier: EMA as old + alpha*(raw-old) >> 16, or yaw gain
	always_comb begin
		case (cmd.mul_sel)
			MUL_X: begin
				mul_a = MUL_A_W'(vx_s1) - MUL_A_W'(fvx_q);
				mul_b = {1'b0, lin_weight_eff};
			end
			MUL_Y: begin
				mul_a = MUL_A_W'(vy_s1) - MUL_A_W'(fvy_q);
				mul_b = {1'b0, lin_weight_eff};
			end
			MUL_YAW: begin
				mul_a = MUL_A_W'(yaw_s1) - MUL_A_W'(fyaw_q);
				mul_b = {1'b0, yaw_weight_eff};
			end
			default: begin
				mul_a = MUL_A_W'(fyaw_q);
				mul_b = {{(MUL_B_W-SCALE_W){1'b0}}, regs.yaw_gain};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
	end

	always_comb begin
		case (cmd.wb_sel)
			MUL_X:   wb_old = fvx_q;
			MUL_Y:   wb_old = fvy_q;
			default: wb_old = fyaw_q;
		endcase
	end

	// result lies between raw and old, so the low bits are the whole value
	assign ema_sum = PROD_W'(wb_old) + (prod_q >>> ALPHA_FRAC);

	assign scl     = prod_q >>> SCALE_FRAC;
	assign scl_top = scl[PROD_W-1:VW-1];
	always_comb begin
		if ((&scl_top) || !(|scl_top))
			yaw_sat = scl[VW-1:0];
		else
			yaw_sat = {scl[PROD_W-1], {(VW-1){~scl[PROD_W-1]}}};
	end

	// filter and motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvx_q    <= '0;
			fvy_q    <= '0;
			fyaw_q   <= '0;
			primed_q <= 1'b0;
			active_q <= 1'b0;
			age_q    <= '0;
		end else if (cmd.clear) begin
			fvx_q    <= '0;
			fvy_q    <= '0;
			fyaw_q   <= '0;
			primed_q <= 1'b0;
			active_q <= 1'b0;
			age_q    <= '0;
		end else begin
			if (cmd.prime) begin
				fvx_q    <= vx_s1;
				fvy_q    <= vy_s1;
				fyaw_q   <= yaw_s1;
				primed_q <= 1'b1;
			end else if (cmd.wb_en) begin
				case (cmd.wb_sel)
					MUL_X:   fvx_q  <= ema_sum[VW-1:0];
					MUL_Y:   fvy_q  <= ema_sum[VW-1:0];
					default: fyaw_q <= ema_sum[VW-1:0];
				endcase
			end
			if (cmd.start_motion) begin
				active_q <= 1'b1;
				age_q    <= '0;
			end else if (cmd.age_step) begin
				age_q <= age_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			kind_q <= cmd.out_kind;
			if (cmd.out_kind == KIND_MOVE) begin
				vx_out_q  <= fvx_q;
				vy_out_q  <= fvy_q;
				yaw_out_q <= yaw_sat;
			end else begin
				vx_out_q  <= '0;
				vy_out_q  <= '0;
				yaw_out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign vx_out    = vx_out_q;
	assign vy_out    = vy_out_q;
	assign yaw_out   = yaw_out_q;

endmodule

`default_nettype wire

/* src/vcs_ctrl.sv */
// Controller state machine: decodes each latched command and sequences
// the shared multiplier and the output load. Depends on vcs_pkg.
`default_nettype none

module vcs_ctrl import vcs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire vcs_stat_t stat,
	output vcs_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_MX   = 3'd2;
	localparam logic [2:0] S_MY   = 3'd3;
	localparam logic [2:0] S_MYAW = 3'd4;
	localparam logic [2:0] S_WYAW = 3'd5;
	localparam logic [2:0] S_MSC  = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.out_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid)
					state_d = S_DEC;
			end
			S_DEC: begin
				unique case (stat.command)
					CMD_VEL: begin
						if (stat.stop_zone) begin
							cmd.clear = 1'b1;
							kind_d    = KIND_DEADBAND;
							state_d   = S_EMIT;
						end else if (!stat.primed) begin
							cmd.prime        = 1'b1;
							cmd.start_motion = 1'b1;
							kind_d           = KIND_MOVE;
							state_d          = S_MSC;
						end else begin
							cmd.start_motion = 1'b1;
							kind_d           = KIND_MOVE;
							state_d          = S_MX;
						end
					end
					CMD_TICK: begin
						if (!stat.active) begin
							state_d = S_IDLE;
						end else if (stat.timeout_hit) begin
							cmd.clear = 1'b1;
							kind_d    = KIND_TIMEOUT;
							state_d   = S_EMIT;
						end else begin
							cmd.age_step = 1'b1;
							state_d      = S_IDLE;
						end
					end
					CMD_STOP: begin
						cmd.clear = 1'b1;
						kind_d    = KIND_STOP_ACK;
						state_d   = S_EMIT;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_MX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_X;
				state_d     = S_MY;
			end
			S_MY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Y;
				cmd.wb_en   = 1'b1;
				cmd.wb_sel  = MUL_X;
				state_d     = S_MYAW;
			end
			S_MYAW: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_YAW;
				cmd.wb_en   = 1'b1;
				cmd.wb_sel  = MUL_Y;
				state_d     = S_WYAW;
			end
			S_WYAW: begin
				cmd.wb_en  = 1'b1;
				cmd.wb_sel = MUL_YAW;
				state_d    = S_MSC;
			end
			S_MSC: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SCALE;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				// hold here while the previous result is still unclaimed
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_MOVE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

`default_nettype wire

/* tb/tb_velocity_command_smoother_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for velocity_command_smoother_top: an in-file EMA/watchdog predictor.
// Depends on vcs_pkg, vcs_cfg_if, vcs_cmd_if, vcs_move_if and the block's RTL.

module tb_velocity_command_smoother_top;
	import vcs_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;          // unused command code
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [VEL_WIDTH-1:0] VEL_MAX_BITS = {1'b0, {(VEL_WIDTH-1){1'b1}}};
	localparam logic [VEL_WIDTH-1:0] VEL_MIN_BITS = {1'b1, {(VEL_WIDTH-1){1'b0}}};
	localparam longint VEL_HI = (longint'(1) <<< (VEL_WIDTH-1)) - 1;
	localparam longint VEL_LO = -(longint'(1) <<< (VEL_WIDTH-1));
	localparam longint UNITY = longint'(1) <<< ALPHA_FRAC;
	localparam int SETTLE_CYCLES = 20;
	localparam int LIMIT_CYCLES = 400000;
	localparam int ITEMS_PER_PHASE = 128;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]           command;
		logic [VEL_WIDTH-1:0] vx;
		logic [VEL_WIDTH-1:0] vy;
		logic [VEL_WIDTH-1:0] yaw;
	} cmd_item_t;

	typedef struct {
		logic [1:0]           kind;
		logic [VEL_WIDTH-1:0] vx;
		logic [VEL_WIDTH-1:0] vy;
		logic [VEL_WIDTH-1:0] yaw;
	} move_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} stall_mode_e;

	logic clk;
	logic arst_n;

	vcs_cfg_if  cfg_ch();
	vcs_cmd_if  cmd_ch();
	vcs_move_if move_ch();

	velocity_command_smoother_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.in_ch  (cmd_ch),
		.out_ch (move_ch)
	);

	cmd_item_t pending_cmds[$];
	move_t     expected_moves[$];
	int        fail_count = 0;
	int        moves_checked = 0;
	int        cycle_count = 0;

	// predictor copy of the registers
	logic [ALPHA_W-1:0] cfg_lin_weight;
	logic [ALPHA_W-1:0] cfg_yaw_weight;
	logic [SCALE_W-1:0] cfg_scale;
	logic [TMO_W-1:0]   cfg_timeout;
	logic [DB_W-1:0]    cfg_deadband;

	// predictor copy of the motion state
	logic signed [VEL_WIDTH-1:0] filt_vx;
	logic signed [VEL_WIDTH-1:0] filt_vy;
	logic signed [VEL_WIDTH-1:0] filt_yaw;
	bit                          primed;
	bit                          moving;
	logic [AGE_WIDTH-1:0]        idle_age;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic longint abs_val(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [VEL_WIDTH-1:0] to_vel(longint v);
		return v[VEL_WIDTH-1:0];
	endfunction

	function automatic logic [VEL_WIDTH-1:0] rand_bits();
		return VEL_WIDTH'($urandom());
	endfunction

	function automatic longint ema_step(longint raw, longint old, logic [ALPHA_W-1:0] alpha);
		longint a;
		a = (alpha > ALPHA_ONE) ? UNITY : longint'(alpha);
		return (a * raw + (UNITY - a) * old) >>> ALPHA_FRAC;
	endfunction

	function automatic void clear_motion();
		filt_vx = '0;
		filt_vy = '0;
		filt_yaw = '0;
		primed = 1'b0;
		moving = 1'b0;
		idle_age = '0;
	endfunction

	// Advance the predictor by one accepted item; queue the move it causes, if any.
	function automatic void predict_move(cmd_item_t it);
		move_t  m;
		longint vx, vy, yaw, scaled;
		bit     emit;
		vx = longint'($signed(it.vx));
		vy = longint'($signed(it.vy));
		yaw = longint'($signed(it.yaw));
		emit = 1'b0;
		m = '{kind: KIND_MOVE, vx: '0, vy: '0, yaw: '0};
		case (it.command)
		CMD_VEL: begin
			emit = 1'b1;
			if (abs_val(vx) < longint'(cfg_deadband) && abs_val(vy) < longint'(cfg_deadband)
					&& abs_val(yaw) < longint'(cfg_deadband)) begin
				clear_motion();
				m.kind = KIND_DEADBAND;
			end else begin
				idle_age = '0;
				moving = 1'b1;
				if (!primed) begin
					filt_vx = VEL_WIDTH'(vx);
					filt_vy = VEL_WIDTH'(vy);
					filt_yaw = VEL_WIDTH'(yaw);
					primed = 1'b1;
				end else begin
					filt_vx = VEL_WIDTH'(ema_step(vx, longint'(filt_vx), cfg_lin_weight));
					filt_vy = VEL_WIDTH'(ema_step(vy, longint'(filt_vy), cfg_lin_weight));
					filt_yaw = VEL_WIDTH'(ema_step(yaw, longint'(filt_yaw), cfg_yaw_weight));
				end
				scaled = (longint'(filt_yaw) * longint'(cfg_scale)) >>> SCALE_FRAC;
				if (scaled > VEL_HI) scaled = VEL_HI;
				if (scaled < VEL_LO) scaled = VEL_LO;
				m.vx = filt_vx;
				m.vy = filt_vy;
				m.yaw = scaled[VEL_WIDTH-1:0];
			end
		end
		CMD_TICK: begin
			if (moving) begin
				if (idle_age != '1) idle_age = idle_age + 1'b1;
				if (idle_age > cfg_timeout) begin
					clear_motion();
					m.kind = KIND_TIMEOUT;
					emit = 1'b1;
				end
			end
		end
		CMD_STOP: begin
			clear_motion();
			m.kind = KIND_STOP_ACK;
			emit = 1'b1;
		end
		default: begin
		end
		endcase
		if (emit) expected_moves.push_back(m);
	endfunction

	// ---------------- input driver: bursts with random gaps ----------------
	int gap_left = 0;
	int burst_left = 1;

	always @(posedge clk) begin
		cmd_item_t it;
		bit        offer;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				it = pending_cmds.pop_front();
				predict_move(it);
				burst_left--;
				if (burst_left <= 0) begin
					if ($urandom_range(0, 9) == 0) begin
						gap_left = 0;
						burst_left = $urandom_range(30, 80);
					end else begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
						burst_left = $urandom_range(1, 20);
					end
				end
			end
			offer = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (pending_cmds.size() > 0)
				offer = 1'b1;
			cmd_ch.valid <= offer;
			if (offer) begin
				cmd_ch.command <= pending_cmds[0].command;
				cmd_ch.vx_in   <= pending_cmds[0].vx;
				cmd_ch.vy_in   <= pending_cmds[0].vy;
				cmd_ch.yaw_in  <= pending_cmds[0].yaw;
			end
		end
	end

	// ---------------- output receiver: stall patterns, long hold-offs ----------------
	stall_mode_e rx_mode = RX_OPEN;
	int          mode_left = 0;
	int          rx_phase = 0;
	int          hold_left = 0;
	int          holds_done = 0;
	int          next_hold_mark = 300;

	always @(posedge clk) begin
		bit rdy;
		if (!arst_n) begin
			move_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = stall_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			// long hold-off lets the block back up into its input
			if (hold_left == 0 && holds_done < 2 && moves_checked >= next_hold_mark) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
				next_hold_mark += 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
				RX_OPEN:     rdy = 1'b1;
				RX_COIN:     rdy = 1'($urandom_range(0, 1));
				RX_PERIODIC: rdy = (rx_phase % 4) == 0;
				default:     rdy = $urandom_range(0, 7) == 0;
				endcase
			end
			rx_phase++;
			move_ch.ready <= rdy;
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		move_t e;
		if (arst_n && move_ch.valid && move_ch.ready) begin
			if (expected_moves.size() == 0) begin
				$error("move transfer with nothing expected: kind %0d", move_ch.kind);
				fail_count++;
			end else begin
				e = expected_moves.pop_front();
				moves_checked++;
				if (move_ch.kind !== e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, move_ch.kind);
					fail_count++;
				end
				if (move_ch.vx_out !== e.vx) begin
					$error("vx_out: expected %0d, got %0d", $signed(e.vx), $signed(move_ch.vx_out));
					fail_count++;
				end
				if (move_ch.vy_out !== e.vy) begin
					$error("vy_out: expected %0d, got %0d", $signed(e.vy), $signed(move_ch.vy_out));
					fail_count++;
				end
				if (move_ch.yaw_out !== e.yaw) begin
					$error("yaw_out: expected %0d, got %0d", $signed(e.yaw),
						$signed(move_ch.yaw_out));
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------
	task automatic push_cmd(logic [1:0] command, logic [VEL_WIDTH-1:0] vx,
			logic [VEL_WIDTH-1:0] vy, logic [VEL_WIDTH-1:0] yaw);
		cmd_item_t it;
		it.command = command;
		it.vx = vx;
		it.vy = vy;
		it.yaw = yaw;
		pending_cmds.push_back(it);
	endtask

	function automatic logic [VEL_WIDTH-1:0] signed_mag(longint m);
		longint v;
		v = ($urandom_range(0, 1) != 0) ? -m : m;
		return v[VEL_WIDTH-1:0];
	endfunction

	function automatic logic [VEL_WIDTH-1:0] rand_vel();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return rand_bits();
		if (pick < 60)
			return signed_mag(longint'($urandom_range(0, 300)));
		if (pick < 75) begin
			case ($urandom_range(0, 4))
			0: return VEL_MAX_BITS;
			1: return VEL_MIN_BITS;
			2: return '0;
			3: return '1;
			default: return to_vel(1);
			endcase
		end
		return signed_mag(longint'($urandom_range(0, 1 << 20)));
	endfunction

	// magnitude strictly under the current deadband
	function automatic logic [VEL_WIDTH-1:0] under_deadband();
		if (cfg_deadband == 0)
			return '0;
		return signed_mag(longint'($urandom_range(0, cfg_deadband - 1)));
	endfunction

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= addr;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (addr)
		REG_ALPHA_LIN: cfg_lin_weight = data;
		REG_ALPHA_ANG: cfg_yaw_weight = data;
		REG_ANG_SCALE: cfg_scale = data[SCALE_W-1:0];
		REG_TIMEOUT:   cfg_timeout = data[TMO_W-1:0];
		REG_DEADBAND:  cfg_deadband = data[DB_W-1:0];
		default: begin
		end
		endcase
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || expected_moves.size() != 0) @(posedge clk);
		// trailing ticks or spare codes may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_alpha();
		if ($urandom_range(0, 7) == 0)
			return CFG_DATA_W'($urandom_range(65537, 131071));
		return CFG_DATA_W'($urandom_range(0, 65536));
	endfunction

	// One command sequence: some velocity samples, then optionally an ending of some kind.
	task automatic queue_episode(output int added);
		int n, r, k;
		added = 0;
		n = $urandom_range(1, 6);
		repeat (n) push_cmd(CMD_VEL, rand_vel(), rand_vel(), rand_vel());
		added += n;
		r = $urandom_range(0, 9);
		if (r <= 3 || r == 7) begin
			if (r == 7) push_cmd(CMD_SPARE, rand_bits(), rand_bits(), rand_bits());
			k = (cfg_timeout <= 10) ? $urandom_range(0, cfg_timeout + 2) : $urandom_range(0, 6);
			repeat (k) push_cmd(CMD_TICK, rand_bits(), rand_bits(), rand_bits());
			added += k;
		end else if (r <= 5) begin
			push_cmd(CMD_STOP, rand_bits(), rand_bits(), rand_bits());
			added++;
		end else if (r == 6) begin
			push_cmd(CMD_VEL, under_deadband(), under_deadband(), under_deadband());
			added++;
		end
	endtask

	initial begin
		int added, total, phase;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_TICK;
		cmd_ch.vx_in = '0;
		cmd_ch.vy_in = '0;
		cmd_ch.yaw_in = '0;
		move_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = REG_ALPHA_LIN;
		cfg_ch.data = '0;
		cfg_lin_weight = ALPHA_LIN_RST;
		cfg_yaw_weight = ALPHA_ANG_RST;
		cfg_scale = ANG_SCALE_RST;
		cfg_timeout = TIMEOUT_RST;
		cfg_deadband = DEADBAND_RST;
		clear_motion();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset register values
		push_cmd(CMD_VEL, '0, '0, '0);                       // deadband stop while idle
		push_cmd(CMD_VEL, to_vel(6), to_vel(-6), to_vel(6));  // just inside deadband
		push_cmd(CMD_VEL, to_vel(7), '0, '0);                 // first sample primes
		push_cmd(CMD_VEL, VEL_MAX_BITS, VEL_MIN_BITS, VEL_MAX_BITS);
		push_cmd(CMD_VEL, VEL_MIN_BITS, VEL_MAX_BITS, VEL_MIN_BITS);
		repeat (6) push_cmd(CMD_TICK, '0, '0, '0);            // sixth tick times out
		push_cmd(CMD_TICK, '1, '1, '1);                       // tick while idle
		push_cmd(CMD_VEL, VEL_MIN_BITS, VEL_MIN_BITS, VEL_MIN_BITS);
		push_cmd(CMD_STOP, '1, '1, '1);
		push_cmd(CMD_SPARE, VEL_MAX_BITS, '0, '1);            // unused code ignored
		push_cmd(CMD_VEL, to_vel(100), to_vel(200), VEL_MAX_BITS);
		push_cmd(CMD_VEL, '0, '0, to_vel(-7));                // yaw at deadband is motion
		push_cmd(CMD_TICK, '0, '0, '0);
		push_cmd(CMD_VEL, to_vel(-1), to_vel(1), to_vel(-1));
		push_cmd(CMD_STOP, '0, '0, '0);
		push_cmd(CMD_TICK, '0, '0, '0);
		wait_drained();

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
			0: begin
				write_reg(REG_ALPHA_LIN, '0);
				write_reg(REG_ALPHA_ANG, ALPHA_ONE);
				write_reg(REG_ANG_SCALE, CFG_DATA_W'(16'hFFFF));
				write_reg(REG_TIMEOUT, '0);
				write_reg(REG_DEADBAND, '0);
			end
			1: begin
				write_reg(REG_ALPHA_LIN, 17'h1FFFF);              // above one, clamps
				write_reg(REG_ALPHA_ANG, '0);
				write_reg(REG_ANG_SCALE, '0);
				write_reg(REG_TIMEOUT, CFG_DATA_W'(16'hFFFF));    // never fires
				write_reg(REG_DEADBAND, CFG_DATA_W'(16'hFFFF));
			end
			2: begin
				write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom()));
				write_reg(REG_ALPHA_LIN, rand_alpha());
				write_reg(REG_ALPHA_ANG, rand_alpha());
				write_reg(REG_ANG_SCALE, 17'h11000);              // top bit dropped
				write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(0, 8)));
				write_reg(REG_DEADBAND, CFG_DATA_W'($urandom_range(0, 500)));
				write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom()));
			end
			7: begin
				write_reg(REG_ALPHA_LIN, ALPHA_LIN_RST);
				write_reg(REG_ALPHA_ANG, ALPHA_ANG_RST);
				write_reg(REG_ANG_SCALE, CFG_DATA_W'(ANG_SCALE_RST));
				write_reg(REG_TIMEOUT, CFG_DATA_W'(TIMEOUT_RST));
				write_reg(REG_DEADBAND, CFG_DATA_W'(DEADBAND_RST));
			end
			default: begin
				write_reg(REG_ALPHA_LIN, rand_alpha());
				write_reg(REG_ALPHA_ANG, rand_alpha());
				write_reg(REG_ANG_SCALE, CFG_DATA_W'($urandom_range(0, 65535)));
				write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(0, 8)));
				write_reg(REG_DEADBAND, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 65535) : $urandom_range(0, 500)));
			end
			endcase
			total = 0;
			while (total < ITEMS_PER_PHASE) begin
				queue_episode(added);
				total += added;
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
